@@ rtl/ptr_pkg.sv @@
// shared types, constants and control program for the temperature regulator
`default_nettype none

package ptr_pkg;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int ERR_W     = SAMPLE_W + 1;
   localparam int ESUM_W    = SAMPLE_W + 2;
   localparam int INTEG_W   = 32;
   localparam int DERIV_W   = 27;
   localparam int MUL_A_W   = 32;
   localparam int MUL_B_W   = GAIN_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int CMD_W     = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PC_W      = 4;

   // command constants
   localparam logic [CMD_W-1:0] CMD_ONOFF = 15'd12800;
   localparam logic [CMD_W-1:0] CMD_MAX   = 15'd25600;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATE = 3'd6;

   // mode codes
   localparam logic [1:0] MODE_ONOFF = 2'd1;
   localparam logic [1:0] MODE_PID   = 2'd2;

   // program addresses
   localparam logic [PC_W-1:0] PC_START  = 4'd0;
   localparam logic [PC_W-1:0] PC_PID    = 4'd1;
   localparam logic [PC_W-1:0] PC_FIN    = 4'd7;
   localparam logic [PC_W-1:0] PC_ONOFF  = 4'd8;
   localparam logic [PC_W-1:0] PC_BAD    = 4'd9;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] temperature;
      logic                       restart;
   } req_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             mode_error;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                 mode;
      logic signed [SAMPLE_W-1:0] setpoint;
      logic [GAIN_W-1:0]          gain_p;
      logic [GAIN_W-1:0]          gain_i;
      logic [GAIN_W-1:0]          gain_d;
      logic [GAIN_W-1:0]          step_time;
      logic [GAIN_W-1:0]          step_rate;
   } cfg_type;

   typedef enum logic [2:0] {
      A_E, A_ESUM, A_EDIFF, A_INTEG, A_DERIV
   } a_sel_type;

   typedef enum logic [2:0] {
      B_GP, B_GI, B_GD, B_DT, B_RATE
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT, JMP_FIRST, JMP_MODE
   } jmp_type;

   typedef enum logic [1:0] {
      FIN_NONE, FIN_PID, FIN_ONOFF, FIN_BAD
   } fin_type;

   // one control word per program step
   typedef struct packed {
      logic            err_ld;
      logic            mul_en;
      a_sel_type       a_sel;
      b_sel_type       b_sel;
      acc_op_type      acc_op;
      logic            integ_ld;
      logic            deriv_ld;
      jmp_type         jmp;
      logic [PC_W-1:0] target;
      fin_type         fin;
   } ucode_type;

   // control program
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      w = '{err_ld: 1'b0, mul_en: 1'b0, a_sel: A_E, b_sel: B_GP, acc_op: ACC_HOLD,
            integ_ld: 1'b0, deriv_ld: 1'b0, jmp: JMP_NEXT, target: PC_START,
            fin: FIN_NONE};
      unique case (addr)
         4'd0: begin
            // error from setpoint, branch on mode
            w.err_ld = 1'b1;
            w.jmp    = JMP_MODE;
         end
         4'd1: begin
            w.mul_en = 1'b1;
            w.a_sel  = A_E;
            w.b_sel  = B_GP;
         end
         4'd2: begin
            // proportional term, trapezoid product, skip history on first sample
            w.acc_op = ACC_LOAD;
            w.mul_en = 1'b1;
            w.a_sel  = A_ESUM;
            w.b_sel  = B_DT;
            w.jmp    = JMP_FIRST;
            w.target = PC_FIN;
         end
         4'd3: begin
            w.integ_ld = 1'b1;
            w.mul_en   = 1'b1;
            w.a_sel    = A_EDIFF;
            w.b_sel    = B_RATE;
         end
         4'd4: begin
            w.deriv_ld = 1'b1;
            w.mul_en   = 1'b1;
            w.a_sel    = A_INTEG;
            w.b_sel    = B_GI;
         end
         4'd5: begin
            w.acc_op = ACC_ADD;
            w.mul_en = 1'b1;
            w.a_sel  = A_DERIV;
            w.b_sel  = B_GD;
         end
         4'd6: begin
            w.acc_op = ACC_ADD;
         end
         4'd7: begin
            w.fin = FIN_PID;
         end
         4'd8: begin
            w.fin = FIN_ONOFF;
         end
         4'd9: begin
            w.fin = FIN_BAD;
         end
         default: begin
            w.fin = FIN_BAD;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/pid_temperature_regulator.sv @@
// top level of the temperature regulator: registers, program sequencer, result register
//
//  channel  ports                          direction  transfer
//  request  req_valid req_ready req_data   in         valid & ready
//  result   rsp_valid rsp_ready rsp_data   out        valid & ready
//  csr      csr_we csr_index csr_wdata     in         csr_we, no wait
//
// one request at a time; the single shared multiplier sets the step count.
// PID runs program steps 0 to 7 (steps 3 to 6 are skipped on the first sample of a run),
// on/off and bad mode go from the start step to their own final step. req_ready is high
// while no program runs. the last step waits while the result register is still full.
// synchronous active-high reset loads the register defaults and clears history.
`default_nettype none

module pid_temperature_regulator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire ptr_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output ptr_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [ptr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ptr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   ptr_pkg::cfg_type   cfg_ff;
   logic               busy_ff, busy_in;
   logic [ptr_pkg::PC_W-1:0] pc_ff, pc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ptr_pkg::rsp_type   rsp_data_ff;
   ptr_pkg::ucode_type ctrl;
   ptr_pkg::rsp_type   result;
   logic               first_pending;
   logic               load;
   logic               stall;
   logic               step_en;
   logic               out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= ptr_pkg::MODE_PID;
         cfg_ff.setpoint  <= 16'sd5120;
         cfg_ff.gain_p    <= 16'd256;
         cfg_ff.gain_i    <= '0;
         cfg_ff.gain_d    <= '0;
         cfg_ff.step_time <= 16'd256;
         cfg_ff.step_rate <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            ptr_pkg::CSR_MODE:      cfg_ff.mode      <= csr_wdata[1:0];
            ptr_pkg::CSR_SETPOINT:  cfg_ff.setpoint  <= csr_wdata;
            ptr_pkg::CSR_GAIN_P:    cfg_ff.gain_p    <= csr_wdata;
            ptr_pkg::CSR_GAIN_I:    cfg_ff.gain_i    <= csr_wdata;
            ptr_pkg::CSR_GAIN_D:    cfg_ff.gain_d    <= csr_wdata;
            ptr_pkg::CSR_STEP_TIME: cfg_ff.step_time <= csr_wdata;
            ptr_pkg::CSR_STEP_RATE: cfg_ff.step_rate <= csr_wdata;
            default: ;
         endcase
      end
   end

   // program fetch and handshake control
   assign ctrl      = ptr_pkg::ucode_rom(pc_ff);
   assign req_ready = !busy_ff;
   assign load      = req_valid && !busy_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stall     = (ctrl.fin != ptr_pkg::FIN_NONE) && !out_free;
   assign step_en   = busy_ff && !stall;

   // next step
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (load) begin
            busy_in = 1'b1;
            pc_in   = ptr_pkg::PC_START;
         end
      end else if (step_en) begin
         priority if (ctrl.fin != ptr_pkg::FIN_NONE) begin
            busy_in = 1'b0;
         end else if (ctrl.jmp == ptr_pkg::JMP_MODE) begin
            if (cfg_ff.mode == ptr_pkg::MODE_PID) begin
               pc_in = ptr_pkg::PC_PID;
            end else if (cfg_ff.mode == ptr_pkg::MODE_ONOFF) begin
               pc_in = ptr_pkg::PC_ONOFF;
            end else begin
               pc_in = ptr_pkg::PC_BAD;
            end
         end else if (ctrl.jmp == ptr_pkg::JMP_FIRST && first_pending) begin
            pc_in = ctrl.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= ptr_pkg::PC_START;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step_en && ctrl.fin != ptr_pkg::FIN_NONE) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && ctrl.fin != ptr_pkg::FIN_NONE) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // datapath
   ptr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .req_data      (req_data),
      .cfg           (cfg_ff),
      .step_en       (step_en),
      .ctrl          (ctrl),
      .first_pending (first_pending),
      .result        (result)
   );

endmodule

`default_nettype wire

@@ rtl/ptr_datapath.sv @@
// regulator datapath: shared multiplier, accumulator and controller history
`default_nettype none

module ptr_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire ptr_pkg::req_type  req_data,
   input  wire ptr_pkg::cfg_type  cfg,
   input  wire logic              step_en,
   input  wire ptr_pkg::ucode_type ctrl,
   output logic                   first_pending,
   output ptr_pkg::rsp_type       result
);

   logic signed [ptr_pkg::SAMPLE_W-1:0] temp_ff;
   logic signed [ptr_pkg::ERR_W-1:0]    e_ff, e_in;
   logic signed [ptr_pkg::ERR_W-1:0]    prev_ff;
   logic signed [ptr_pkg::INTEG_W-1:0]  integral_ff;
   logic signed [ptr_pkg::INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [ptr_pkg::DERIV_W-1:0]  deriv_ff;
   logic signed [ptr_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ptr_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic                                first_ff;

   logic signed [ptr_pkg::ESUM_W-1:0]   esum, ediff;
   logic signed [ptr_pkg::MUL_A_W-1:0]  mul_a;
   logic signed [ptr_pkg::MUL_B_W-1:0]  mul_b;
   logic signed [ptr_pkg::ACC_W-1:0]    prod_ext;
   logic signed [ptr_pkg::INTEG_W+8:0]  int_sum;
   logic [ptr_pkg::ACC_W-9:0]           cmd_full;

   // error and its history terms
   assign e_in  = {cfg.setpoint[ptr_pkg::SAMPLE_W-1], cfg.setpoint}
                - {temp_ff[ptr_pkg::SAMPLE_W-1], temp_ff};
   assign esum  = {e_ff[ptr_pkg::ERR_W-1], e_ff} + {prev_ff[ptr_pkg::ERR_W-1], prev_ff};
   assign ediff = {e_ff[ptr_pkg::ERR_W-1], e_ff} - {prev_ff[ptr_pkg::ERR_W-1], prev_ff};

   // multiplier operand select
   always_comb begin
      unique case (ctrl.a_sel)
         ptr_pkg::A_E:     mul_a = {{(ptr_pkg::MUL_A_W-ptr_pkg::ERR_W){e_ff[ptr_pkg::ERR_W-1]}},
                                    e_ff};
         ptr_pkg::A_ESUM:  mul_a = {{(ptr_pkg::MUL_A_W-ptr_pkg::ESUM_W){esum[ptr_pkg::ESUM_W-1]}},
                                    esum};
         ptr_pkg::A_EDIFF: mul_a = {{(ptr_pkg::MUL_A_W-ptr_pkg::ESUM_W){ediff[ptr_pkg::ESUM_W-1]}},
                                    ediff};
         ptr_pkg::A_INTEG: mul_a = integ_ff;
         ptr_pkg::A_DERIV: mul_a = {{(ptr_pkg::MUL_A_W-ptr_pkg::DERIV_W){deriv_ff[ptr_pkg::DERIV_W-1]}},
                                    deriv_ff};
         default:          mul_a = '0;
      endcase
   end

   always_comb begin
      unique case (ctrl.b_sel)
         ptr_pkg::B_GP:   mul_b = {1'b0, cfg.gain_p};
         ptr_pkg::B_GI:   mul_b = {1'b0, cfg.gain_i};
         ptr_pkg::B_GD:   mul_b = {1'b0, cfg.gain_d};
         ptr_pkg::B_DT:   mul_b = {1'b0, cfg.step_time};
         ptr_pkg::B_RATE: mul_b = {1'b0, cfg.step_rate};
         default:         mul_b = '0;
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {{(ptr_pkg::ACC_W-ptr_pkg::PROD_W){prod_ff[ptr_pkg::PROD_W-1]}}, prod_ff};

   // accumulator
   always_comb begin
      unique case (ctrl.acc_op)
         ptr_pkg::ACC_LOAD: acc_in = prod_ext;
         ptr_pkg::ACC_ADD:  acc_in = acc_ff + prod_ext;
         default:           acc_in = acc_ff;
      endcase
   end

   // trapezoid step added to the integral, saturated to 32 bits
   always_comb begin
      int_sum = {{9{integral_ff[ptr_pkg::INTEG_W-1]}}, integral_ff}
              + {prod_ff[ptr_pkg::PROD_W-1], prod_ff[ptr_pkg::PROD_W-1:9]};
      if (int_sum[ptr_pkg::INTEG_W+8:ptr_pkg::INTEG_W-1] == '0 ||
          int_sum[ptr_pkg::INTEG_W+8:ptr_pkg::INTEG_W-1] == '1) begin
         integ_in = int_sum[ptr_pkg::INTEG_W-1:0];
      end else if (int_sum[ptr_pkg::INTEG_W+8]) begin
         integ_in = {1'b1, {(ptr_pkg::INTEG_W-1){1'b0}}};
      end else begin
         integ_in = {1'b0, {(ptr_pkg::INTEG_W-1){1'b1}}};
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (load) begin
         temp_ff <= req_data.temperature;
      end
      if (step_en) begin
         if (ctrl.err_ld) begin
            e_ff <= e_in;
         end
         if (ctrl.mul_en) begin
            prod_ff <= prod_in;
         end
         if (ctrl.integ_ld) begin
            integ_ff <= integ_in;
         end
         if (ctrl.deriv_ld) begin
            deriv_ff <= prod_ff[ptr_pkg::DERIV_W+7:8];
         end
         acc_ff <= acc_in;
      end
   end

   // controller history
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         integral_ff <= '0;
         first_ff    <= 1'b1;
      end else if (load && req_data.restart) begin
         first_ff <= 1'b1;
      end else if (step_en && ctrl.fin == ptr_pkg::FIN_PID) begin
         prev_ff     <= e_ff;
         integral_ff <= first_ff ? '0 : integ_ff;
         first_ff    <= 1'b0;
      end
   end

   assign first_pending = first_ff;

   // result formatting
   assign cmd_full = acc_ff[ptr_pkg::ACC_W-1:8];

   always_comb begin
      result = '0;
      unique case (ctrl.fin)
         ptr_pkg::FIN_PID: begin
            if (acc_ff[ptr_pkg::ACC_W-1] || acc_ff == '0) begin
               result.command = '0;
            end else if (cmd_full > (ptr_pkg::ACC_W-8)'(ptr_pkg::CMD_MAX)) begin
               result.command = ptr_pkg::CMD_MAX;
            end else begin
               result.command = cmd_full[ptr_pkg::CMD_W-1:0];
            end
         end
         ptr_pkg::FIN_ONOFF: begin
            result.command = (temp_ff < cfg.setpoint) ? ptr_pkg::CMD_ONOFF : '0;
         end
         ptr_pkg::FIN_BAD: begin
            result.mode_error = 1'b1;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for the temperature regulator: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb_top;

   // mode codes without a package name
   localparam logic [1:0] MODE_OFF = 2'd0;
   localparam logic [1:0] MODE_BAD = 2'd3;
   // index past the last register
   localparam logic [ptr_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   localparam longint INTEG_MAX   = (longint'(1) <<< 31) - 1;
   localparam longint INTEG_MIN   = -(longint'(1) <<< 31);
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     HOLD_CYCLES = 300;
   localparam int     SETTLE_CYCLES = 20;

   logic                           clock;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   ptr_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   ptr_pkg::rsp_type               rsp_data;
   logic                           csr_we    = 1'b0;
   logic [ptr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ptr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and the controller history
   ptr_pkg::cfg_type model_cfg = '{mode: ptr_pkg::MODE_PID, setpoint: 16'sd5120,
                                   gain_p: 16'd256, gain_i: 16'd0, gain_d: 16'd0,
                                   step_time: 16'd256, step_rate: 16'd256};
   longint  last_error   = 0;
   longint  integral_acc = 0;
   logic    run_start    = 1'b1;

   ptr_pkg::rsp_type expected_commands[$];
   int      mismatches    = 0;
   int      cycle_count   = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_requests = 0;
   int      hold_seen     = 0;
   int      hold_left     = 0;

   pid_temperature_regulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** pid_temperature_regulator: FAILED **");
         $finish;
      end
   end

   // result side ready: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endfunction

   // compare each result with the oldest expected command
   always @(posedge clock) begin
      ptr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_commands.size() == 0) begin
            note_mismatch($sformatf("unexpected result: command %0d mode_error %0b",
                                    rsp_data.command, rsp_data.mode_error));
         end else begin
            want = expected_commands.pop_front();
            if (rsp_data.command !== want.command)
               note_mismatch($sformatf("command: expected %0d, got %0d",
                                       want.command, rsp_data.command));
            if (rsp_data.mode_error !== want.mode_error)
               note_mismatch($sformatf("mode_error: expected %0b, got %0b",
                                       want.mode_error, rsp_data.mode_error));
         end
      end
   end

   // heating command for one sample, advancing the controller history
   function automatic ptr_pkg::rsp_type predict_heating(input ptr_pkg::req_type sample);
      ptr_pkg::rsp_type outcome;
      longint  err;
      longint  integ;
      longint  deriv;
      longint  total;
      outcome = '0;
      if (sample.restart)
         run_start = 1'b1;
      if (model_cfg.mode == ptr_pkg::MODE_ONOFF) begin
         if ($signed(sample.temperature) < $signed(model_cfg.setpoint))
            outcome.command = ptr_pkg::CMD_ONOFF;
      end else if (model_cfg.mode == ptr_pkg::MODE_PID) begin
         err = longint'($signed(model_cfg.setpoint)) - longint'($signed(sample.temperature));
         if (run_start) begin
            integ = 0;
            deriv = 0;
         end else begin
            // trapezoid step, then saturate the running sum
            integ = integral_acc
                  + (((err + last_error) * longint'(model_cfg.step_time)) >>> 9);
            if (integ > INTEG_MAX)
               integ = INTEG_MAX;
            if (integ < INTEG_MIN)
               integ = INTEG_MIN;
            deriv = ((err - last_error) * longint'(model_cfg.step_rate)) >>> 8;
         end
         total = longint'(model_cfg.gain_p) * err + longint'(model_cfg.gain_i) * integ
               + longint'(model_cfg.gain_d) * deriv;
         if (total > 0) begin
            if ((total >>> 8) > longint'(ptr_pkg::CMD_MAX))
               outcome.command = ptr_pkg::CMD_MAX;
            else
               outcome.command = ptr_pkg::CMD_W'(total >>> 8);
         end
         last_error   = err;
         integral_acc = integ;
         run_start    = 1'b0;
      end else begin
         outcome.mode_error = 1'b1;
      end
      return outcome;
   endfunction

   // register write, only while nothing is in flight
   task automatic csr_write(input logic [ptr_pkg::CSR_IDX_W-1:0] index,
                            input logic [ptr_pkg::CSR_DATA_W-1:0] data);
      case (index)
         ptr_pkg::CSR_MODE:      model_cfg.mode      = data[1:0];
         ptr_pkg::CSR_SETPOINT:  model_cfg.setpoint  = data;
         ptr_pkg::CSR_GAIN_P:    model_cfg.gain_p    = data;
         ptr_pkg::CSR_GAIN_I:    model_cfg.gain_i    = data;
         ptr_pkg::CSR_GAIN_D:    model_cfg.gain_d    = data;
         ptr_pkg::CSR_STEP_TIME: model_cfg.step_time = data;
         ptr_pkg::CSR_STEP_RATE: model_cfg.step_rate = data;
         default: ;
      endcase
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // offer one request, record its expected command on acceptance
   task automatic send_sample(input logic signed [ptr_pkg::SAMPLE_W-1:0] temperature,
                              input logic restart);
      ptr_pkg::req_type item;
      item.temperature = temperature;
      item.restart     = restart;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 60);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_commands.push_back(predict_heating(item));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_commands.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(65535));
         default: return 16'($urandom_range(1, 1024));
      endcase
   endfunction

   function automatic logic [15:0] pick_setpoint();
      int value;
      value = int'($urandom_range(20000)) - 10000;
      case ($urandom_range(7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(65535));
         default: return 16'(value);
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return ptr_pkg::MODE_PID;
         6, 7:             return ptr_pkg::MODE_ONOFF;
         8:                return MODE_OFF;
         default:          return MODE_BAD;
      endcase
   endfunction

   task automatic apply_random_settings();
      drain_results();
      // upper data bits of the mode write are don't-care
      csr_write(ptr_pkg::CSR_MODE, {14'($urandom), pick_mode()});
      csr_write(ptr_pkg::CSR_SETPOINT, pick_setpoint());
      csr_write(ptr_pkg::CSR_GAIN_P, pick_gain());
      csr_write(ptr_pkg::CSR_GAIN_I, pick_gain());
      csr_write(ptr_pkg::CSR_GAIN_D, pick_gain());
      csr_write(ptr_pkg::CSR_STEP_TIME, pick_gain());
      csr_write(ptr_pkg::CSR_STEP_RATE, pick_gain());
   endtask

   // mostly a drifting error around the setpoint, some raw noise
   task automatic stream_samples(input int count);
      int   err_target;
      int   temp_value;
      logic opening;
      err_target = int'($urandom_range(12800)) - 2560;
      opening    = 1'b1;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0) begin
            send_sample(16'($urandom), 1'($urandom));
         end else begin
            err_target += int'($urandom_range(1280)) - 640;
            if (err_target < -12800)
               err_target = -12800;
            if (err_target > 38400)
               err_target = 38400;
            temp_value = int'($signed(model_cfg.setpoint)) - err_target;
            if (temp_value < -32768)
               temp_value = -32768;
            if (temp_value > 32767)
               temp_value = 32767;
            send_sample(16'(temp_value), opening || ($urandom_range(59) == 0));
            opening = 1'b0;
         end
      end
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (4) begin
         apply_random_settings();
         stream_samples($urandom_range(55, 90));
      end
   endtask

   // default registers straight after reset, first sample has no history
   task automatic test_reset_defaults();
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd5120, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
   endtask

   // on/off: below, equal, above setpoint and range ends
   task automatic test_onoff_mode();
      drain_results();
      csr_write(ptr_pkg::CSR_MODE, {14'h0000, ptr_pkg::MODE_ONOFF});
      csr_write(ptr_pkg::CSR_SETPOINT, 16'd2560);
      send_sample(16'sd2560, 1'b0);
      send_sample(16'sd2559, 1'b0);
      send_sample(16'sd2561, 1'b0);
      send_sample(16'h8000, 1'b1);
      drain_results();
      csr_write(ptr_pkg::CSR_SETPOINT, 16'h7FFF);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'sd32766, 1'b0);
   endtask

   // invalid modes flag an error and keep history apart from restart
   task automatic test_invalid_mode();
      drain_results();
      csr_write(ptr_pkg::CSR_MODE, {14'h0000, MODE_OFF});
      csr_write(ptr_pkg::CSR_GAIN_I, 16'd300);
      csr_write(ptr_pkg::CSR_GAIN_D, 16'd200);
      send_sample(16'sd100, 1'b0);
      drain_results();
      csr_write(ptr_pkg::CSR_MODE, {14'h0000, MODE_BAD});
      send_sample(16'sd7000, 1'b1);
      drain_results();
      csr_write(CSR_UNUSED, 16'hFFFF);
      csr_write(ptr_pkg::CSR_MODE, {14'h3FFF, ptr_pkg::MODE_PID});
      send_sample(16'sd30000, 1'b0);
      send_sample(16'sd29000, 1'b0);
   endtask

   // full-scale gains, zero step time then zero step rate
   task automatic test_pid_extremes();
      drain_results();
      csr_write(ptr_pkg::CSR_SETPOINT, 16'h8000);
      csr_write(ptr_pkg::CSR_GAIN_P, 16'hFFFF);
      csr_write(ptr_pkg::CSR_GAIN_I, 16'hFFFF);
      csr_write(ptr_pkg::CSR_GAIN_D, 16'hFFFF);
      csr_write(ptr_pkg::CSR_STEP_TIME, 16'h0000);
      csr_write(ptr_pkg::CSR_STEP_RATE, 16'hFFFF);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'sd0, 1'b0);
      drain_results();
      csr_write(ptr_pkg::CSR_SETPOINT, 16'h7FFF);
      csr_write(ptr_pkg::CSR_STEP_TIME, 16'hFFFF);
      csr_write(ptr_pkg::CSR_STEP_RATE, 16'h0000);
      csr_write(ptr_pkg::CSR_GAIN_P, 16'h0000);
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
   endtask

   // drive the integral into both limits, then expose the held value
   // through a proportional term that nearly cancels it
   task automatic test_integral_windup();
      drain_results();
      csr_write(ptr_pkg::CSR_MODE, {14'h0000, ptr_pkg::MODE_PID});
      csr_write(ptr_pkg::CSR_SETPOINT, 16'h7FFF);
      csr_write(ptr_pkg::CSR_GAIN_P, 16'h0000);
      csr_write(ptr_pkg::CSR_GAIN_I, 16'h0001);
      csr_write(ptr_pkg::CSR_GAIN_D, 16'h0000);
      csr_write(ptr_pkg::CSR_STEP_TIME, 16'hFFFF);
      for (int n = 0; n < 150; n++)
         send_sample(16'h8000, n == 0);
      drain_results();
      csr_write(ptr_pkg::CSR_STEP_TIME, 16'h0000);
      csr_write(ptr_pkg::CSR_GAIN_P, 16'hFFFF);
      csr_write(ptr_pkg::CSR_SETPOINT, 16'h0000);
      repeat (10)
         send_sample(16'(32722 + $urandom_range(20)), 1'b0);
      drain_results();
      csr_write(ptr_pkg::CSR_SETPOINT, 16'h8000);
      csr_write(ptr_pkg::CSR_GAIN_P, 16'h0000);
      csr_write(ptr_pkg::CSR_STEP_TIME, 16'hFFFF);
      repeat (290)
         send_sample(16'h7FFF, 1'b0);
      drain_results();
      csr_write(ptr_pkg::CSR_STEP_TIME, 16'h0000);
      csr_write(ptr_pkg::CSR_GAIN_P, 16'hFFFF);
      csr_write(ptr_pkg::CSR_SETPOINT, 16'h7FFF);
      repeat (10)
         send_sample(16'(-48 + int'($urandom_range(20))), 1'b0);
   endtask

   // result side holds off while requests keep coming, input must stall
   task automatic test_input_stall();
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests <= hold_requests + 1;
      repeat (24)
         send_sample(16'($urandom), ($urandom_range(7) == 0));
   endtask

   // test sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 69;
      test_reset_defaults();
      test_onoff_mode();
      test_invalid_mode();
      test_pid_extremes();
      test_integral_windup();
      test_input_stall();
      run_random_phase(16, 69);
      run_random_phase(69, 16);
      run_random_phase(0, 0);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_commands.size() == 0)
         $display("** pid_temperature_regulator: PASSED **");
      else
         $display("** pid_temperature_regulator: FAILED **");
      $finish;
   end

endmodule

@@ pid_temperature_regulator.f @@
rtl/ptr_pkg.sv
rtl/ptr_datapath.sv
rtl/pid_temperature_regulator.sv
dv/tb_top.sv
